/* rtl/jded_pkg.sv */
// ----------------------------------------------------------------------------
// jded_pkg
// Shared widths, register indexes, event codes and reset values of the
// joystick direction event detector.
// ----------------------------------------------------------------------------
package jded_pkg;

	localparam int TIME_W       = 32;
	localparam int FIELD_W      = 60;
	localparam int CENTER_W     = 12;
	localparam int LIMIT_W      = 8;
	localparam int INTERVAL_W   = 16;
	localparam int CFG_IDX_W    = 3;
	localparam int CFG_DATA_W   = 16;
	localparam int NUM_EVENTS   = 6;
	localparam int MAX_EVENTS   = 4;
	localparam int CODE_W       = 3;

	localparam int DEF_SAMPLES_PER_POLL = 5;
	localparam int DEF_SAMPLE_BITS      = 12;

	localparam int SCALE_MUL    = 128;
	localparam int SCALE_DIV    = 2048;
	localparam int SCALE_SHIFT  = $clog2(SCALE_DIV) - $clog2(SCALE_MUL);
	localparam int SCALED_MAX   = 127;
	localparam int SCALED_MIN   = -128;

	localparam logic [CENTER_W-1:0]        RST_ADC_CENTER  = 12'd1967;
	localparam logic signed [LIMIT_W-1:0]  RST_LEFT_LIMIT  = -8'sd100;
	localparam logic signed [LIMIT_W-1:0]  RST_RIGHT_LIMIT = 8'sd90;
	localparam logic signed [LIMIT_W-1:0]  RST_UP_LIMIT    = 8'sd100;
	localparam logic signed [LIMIT_W-1:0]  RST_DOWN_LIMIT  = -8'sd100;
	localparam logic [INTERVAL_W-1:0]      RST_INTERVAL    = 16'd100;

	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_ADC_CENTER = 3'd0,
		CFG_LEFT_LIMIT = 3'd1,
		CFG_RIGHT_LIMIT = 3'd2,
		CFG_UP_LIMIT = 3'd3,
		CFG_DOWN_LIMIT = 3'd4,
		CFG_POLL_INTERVAL = 3'd5
	} cfg_idx_t;

	typedef enum logic [CODE_W-1:0] {
		EV_LEFT = 3'd0,
		EV_RIGHT = 3'd1,
		EV_UP = 3'd2,
		EV_DOWN = 3'd3,
		EV_A_CLICK = 3'd4,
		EV_B_CLICK = 3'd5
	} ev_code_t;

	typedef struct packed {
		logic s2;
		logic s3;
		logic s4;
	} stage_en_t;

	typedef struct packed {
		logic lo;
		logic hi;
	} axis_hit_t;

endpackage

/* rtl/joystick_direction_event_detector_core.sv */
// ----------------------------------------------------------------------------
// joystick_direction_event_detector_core
// Path: an accepted poll passes stages s1 to s4 and the merge's pending and
// output registers. Throughput: one poll per cycle while out_stall is low; a
// poll with n new events (n at most 4) stalls input until its last is loaded.
// Reset: asynchronous; clears the pipeline, held flags and last poll time and
// loads the configuration registers with their reset values. No clearing pass.
// ----------------------------------------------------------------------------
module joystick_direction_event_detector_core #(
	parameter int SAMPLES_PER_POLL = jded_pkg::DEF_SAMPLES_PER_POLL,
	parameter int SAMPLE_BITS      = jded_pkg::DEF_SAMPLE_BITS
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                cfg_we,
	input  logic [jded_pkg::CFG_IDX_W-1:0]      cfg_idx,
	input  logic [jded_pkg::CFG_DATA_W-1:0]     cfg_wdata,
	input  logic                                in_valid,
	output logic                                in_stall,
	input  logic [jded_pkg::TIME_W-1:0]         now_ms,
	input  logic [jded_pkg::FIELD_W-1:0]        x_samples,
	input  logic [jded_pkg::FIELD_W-1:0]        y_samples,
	input  logic                                button_a,
	input  logic                                button_b,
	output logic                                out_valid,
	input  logic                                out_stall,
	output logic [jded_pkg::CODE_W-1:0]         event_code,
	output logic                                last_event
);

	logic [jded_pkg::CENTER_W-1:0]          adc_center_q;
	logic signed [jded_pkg::LIMIT_W-1:0]    left_limit_q;
	logic signed [jded_pkg::LIMIT_W-1:0]    right_limit_q;
	logic signed [jded_pkg::LIMIT_W-1:0]    up_limit_q;
	logic signed [jded_pkg::LIMIT_W-1:0]    down_limit_q;
	logic [jded_pkg::INTERVAL_W-1:0]        interval_q;
	logic [jded_pkg::TIME_W-1:0]            last_ms_q;

	logic [jded_pkg::TIME_W-1:0]            elapsed;
	logic                                   in_beat;
	logic                                   pass;
	logic                                   v1_s1, v2_s2, v3_s3, v4_s4;
	logic                                   rdy1, rdy2, rdy3, rdy4;
	logic [jded_pkg::FIELD_W-1:0]           x_s1, y_s1;
	logic [1:0]                             btn_s1, btn_s2, btn_s3, btn_s4;
	jded_pkg::stage_en_t                    en;
	jded_pkg::axis_hit_t                    x_hit_s4, y_hit_s4;
	logic [jded_pkg::NUM_EVENTS-1:0]        cond;
	logic                                   merge_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			adc_center_q  <= jded_pkg::RST_ADC_CENTER;
			left_limit_q  <= jded_pkg::RST_LEFT_LIMIT;
			right_limit_q <= jded_pkg::RST_RIGHT_LIMIT;
			up_limit_q    <= jded_pkg::RST_UP_LIMIT;
			down_limit_q  <= jded_pkg::RST_DOWN_LIMIT;
			interval_q    <= jded_pkg::RST_INTERVAL;
		end else if (cfg_we) begin
			case (cfg_idx)
				jded_pkg::CFG_ADC_CENTER: adc_center_q <= cfg_wdata[jded_pkg::CENTER_W-1:0];
				jded_pkg::CFG_LEFT_LIMIT: left_limit_q <= cfg_wdata[jded_pkg::LIMIT_W-1:0];
				jded_pkg::CFG_RIGHT_LIMIT: right_limit_q <= cfg_wdata[jded_pkg::LIMIT_W-1:0];
				jded_pkg::CFG_UP_LIMIT: up_limit_q <= cfg_wdata[jded_pkg::LIMIT_W-1:0];
				jded_pkg::CFG_DOWN_LIMIT: down_limit_q <= cfg_wdata[jded_pkg::LIMIT_W-1:0];
				jded_pkg::CFG_POLL_INTERVAL: interval_q <= cfg_wdata[jded_pkg::INTERVAL_W-1:0];
				default: begin
				end
			endcase
		end
	end

	assign rdy4 = !v4_s4 || merge_ready;
	assign rdy3 = !v3_s3 || rdy4;
	assign rdy2 = !v2_s2 || rdy3;
	assign rdy1 = !v1_s1 || rdy2;
	assign in_stall = !rdy1;

	assign en.s2 = rdy2;
	assign en.s3 = rdy3;
	assign en.s4 = rdy4;

	assign in_beat = in_valid && rdy1;
	assign elapsed = now_ms - last_ms_q;
	assign pass    = elapsed >= jded_pkg::TIME_W'(interval_q);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			last_ms_q <= '0;
			v1_s1     <= 1'b0;
			v2_s2     <= 1'b0;
			v3_s3     <= 1'b0;
			v4_s4     <= 1'b0;
		end else begin
			if (in_beat && pass) begin
				last_ms_q <= now_ms;
			end
			if (rdy1) begin
				v1_s1 <= in_beat && pass;
			end
			if (rdy2) begin
				v2_s2 <= v1_s1;
			end
			if (rdy3) begin
				v3_s3 <= v2_s2;
			end
			if (rdy4) begin
				v4_s4 <= v3_s3;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (rdy1) begin
			x_s1   <= x_samples;
			y_s1   <= y_samples;
			btn_s1 <= {button_b, button_a};
		end
		if (rdy2) begin
			btn_s2 <= btn_s1;
		end
		if (rdy3) begin
			btn_s3 <= btn_s2;
		end
		if (rdy4) begin
			btn_s4 <= btn_s3;
		end
	end

	jded_axis_lane #(
		.SAMPLES_PER_POLL (SAMPLES_PER_POLL),
		.SAMPLE_BITS      (SAMPLE_BITS)
	) u_lane_x (
		.clk        (clk),
		.en         (en),
		.samples_s1 (x_s1),
		.center     (adc_center_q),
		.lo_limit   (left_limit_q),
		.hi_limit   (right_limit_q),
		.hit_s4     (x_hit_s4)
	);

	jded_axis_lane #(
		.SAMPLES_PER_POLL (SAMPLES_PER_POLL),
		.SAMPLE_BITS      (SAMPLE_BITS)
	) u_lane_y (
		.clk        (clk),
		.en         (en),
		.samples_s1 (y_s1),
		.center     (adc_center_q),
		.lo_limit   (down_limit_q),
		.hi_limit   (up_limit_q),
		.hit_s4     (y_hit_s4)
	);

	assign cond = {btn_s4[1], btn_s4[0], y_hit_s4.lo, y_hit_s4.hi, x_hit_s4.hi, x_hit_s4.lo};

	jded_event_merge u_merge (
		.clk        (clk),
		.arst_n     (arst_n),
		.cond_valid (v4_s4),
		.cond       (cond),
		.ready      (merge_ready),
		.out_valid  (out_valid),
		.out_stall  (out_stall),
		.event_code (event_code),
		.last_event (last_event)
	);

endmodule

/* rtl/jded_axis_lane.sv */
// ----------------------------------------------------------------------------
// jded_axis_lane
// One axis: sums the packed samples, averages by reciprocal multiply,
// centers, scales toward zero, saturates and checks both limits.
// ----------------------------------------------------------------------------
module jded_axis_lane #(
	parameter int SAMPLES_PER_POLL = jded_pkg::DEF_SAMPLES_PER_POLL,
	parameter int SAMPLE_BITS      = jded_pkg::DEF_SAMPLE_BITS
) (
	input  logic                                       clk,
	input  jded_pkg::stage_en_t                        en,
	input  logic [jded_pkg::FIELD_W-1:0]               samples_s1,
	input  logic [jded_pkg::CENTER_W-1:0]              center,
	input  logic signed [jded_pkg::LIMIT_W-1:0]        lo_limit,
	input  logic signed [jded_pkg::LIMIT_W-1:0]        hi_limit,
	output jded_pkg::axis_hit_t                        hit_s4
);

	localparam int PACK_W    = SAMPLES_PER_POLL * SAMPLE_BITS;
	localparam int EXT_W     = (PACK_W > jded_pkg::FIELD_W) ? PACK_W : jded_pkg::FIELD_W;
	localparam int SUM_W     = SAMPLE_BITS + $clog2(SAMPLES_PER_POLL);
	localparam int DIV_SHIFT = SUM_W + 4;
	localparam int RECIP_W   = DIV_SHIFT + 1;
	localparam longint unsigned RECIP_L =
		((64'd1 << DIV_SHIFT) + SAMPLES_PER_POLL - 1) / SAMPLES_PER_POLL;
	localparam logic [RECIP_W-1:0] RECIP = RECIP_W'(RECIP_L);
	localparam int PROD_W    = SUM_W + RECIP_W;
	localparam int CW        = ((SAMPLE_BITS > jded_pkg::CENTER_W) ?
		SAMPLE_BITS : jded_pkg::CENTER_W) + 1;
	localparam logic signed [CW-1:0] ROUND_ADD = CW'((1 << jded_pkg::SCALE_SHIFT) - 1);
	localparam logic signed [CW-1:0] SAT_HI = CW'(jded_pkg::SCALED_MAX);
	localparam logic signed [CW-1:0] SAT_LO = CW'(jded_pkg::SCALED_MIN);

	logic [EXT_W-1:0]                      ext;
	logic [SUM_W-1:0]                      acc;
	logic [SUM_W-1:0]                      sum_s2;
	logic [PROD_W-1:0]                     prod;
	logic [SAMPLE_BITS-1:0]                avg_s3;
	logic signed [CW-1:0]                  cent;
	logic signed [CW-1:0]                  adj;
	logic signed [CW-1:0]                  quo;
	logic signed [jded_pkg::LIMIT_W-1:0]   scaled;

	assign ext = EXT_W'(samples_s1);

	always_comb begin
		acc = '0;
		for (int i = 0; i < SAMPLES_PER_POLL; i++) begin
			acc = acc + SUM_W'(ext[i*SAMPLE_BITS +: SAMPLE_BITS]);
		end
	end

	assign prod = PROD_W'(sum_s2) * PROD_W'(RECIP);

	always_comb begin
		cent = $signed({{(CW-SAMPLE_BITS){1'b0}}, avg_s3}) -
			$signed({{(CW-jded_pkg::CENTER_W){1'b0}}, center});
		adj = cent[CW-1] ? (cent + ROUND_ADD) : cent;
		quo = adj >>> jded_pkg::SCALE_SHIFT;
		if (quo > SAT_HI) begin
			scaled = jded_pkg::LIMIT_W'(jded_pkg::SCALED_MAX);
		end else if (quo < SAT_LO) begin
			scaled = jded_pkg::LIMIT_W'(jded_pkg::SCALED_MIN);
		end else begin
			scaled = quo[jded_pkg::LIMIT_W-1:0];
		end
	end

	always_ff @(posedge clk) begin
		if (en.s2) begin
			sum_s2 <= acc;
		end
		if (en.s3) begin
			avg_s3 <= prod[DIV_SHIFT +: SAMPLE_BITS];
		end
		if (en.s4) begin
			hit_s4.lo <= (scaled <= lo_limit);
			hit_s4.hi <= (scaled >= hi_limit);
		end
	end

endmodule

/* rtl/jded_event_merge.sv */
// ----------------------------------------------------------------------------
// jded_event_merge
// Combines the lane conditions with the held flags, keeps the first four new
// events of a poll and sends them one beat per cycle, while out_stall is low,
// through an output register.
// ----------------------------------------------------------------------------
module jded_event_merge (
	input  logic                                  clk,
	input  logic                                  arst_n,
	input  logic                                  cond_valid,
	input  logic [jded_pkg::NUM_EVENTS-1:0]       cond,
	output logic                                  ready,
	output logic                                  out_valid,
	input  logic                                  out_stall,
	output logic [jded_pkg::CODE_W-1:0]           event_code,
	output logic                                  last_event
);

	logic [jded_pkg::NUM_EVENTS-1:0] held_q;
	logic [jded_pkg::NUM_EVENTS-1:0] pend_q;
	logic [jded_pkg::NUM_EVENTS-1:0] fresh;
	logic [jded_pkg::NUM_EVENTS-1:0] capped;
	logic [jded_pkg::NUM_EVENTS-1:0] low_bit;
	logic [jded_pkg::NUM_EVENTS-1:0] rest;
	logic [2:0]                      cnt;
	jded_pkg::ev_code_t              next_code;
	logic                            ov_q;
	jded_pkg::ev_code_t              code_q;
	logic                            last_q;
	logic                            slot_free;
	logic                            load;
	logic                            take;

	assign fresh = cond & ~held_q;

	always_comb begin
		cnt = '0;
		capped = '0;
		for (int k = 0; k < jded_pkg::NUM_EVENTS; k++) begin
			if (fresh[k] && (cnt < 3'(jded_pkg::MAX_EVENTS))) begin
				capped[k] = 1'b1;
				cnt = cnt + 3'd1;
			end
		end
	end

	assign low_bit = pend_q & (~pend_q + jded_pkg::NUM_EVENTS'(1));
	assign rest    = pend_q & ~low_bit;

	always_comb begin
		next_code = jded_pkg::EV_LEFT;
		for (int k = jded_pkg::NUM_EVENTS - 1; k >= 0; k--) begin
			if (pend_q[k]) begin
				next_code = jded_pkg::ev_code_t'(jded_pkg::CODE_W'(k));
			end
		end
	end

	assign slot_free = !ov_q || !out_stall;
	assign load      = slot_free && (pend_q != '0);
	assign ready     = (pend_q == '0) || (load && (rest == '0));
	assign take      = cond_valid && ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			held_q <= '0;
			pend_q <= '0;
			ov_q   <= 1'b0;
		end else begin
			if (take) begin
				held_q <= cond;
				pend_q <= capped;
			end else if (load) begin
				pend_q <= rest;
			end
			if (slot_free) begin
				ov_q <= load;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			code_q <= next_code;
			last_q <= (rest == '0);
		end
	end

	assign out_valid  = ov_q;
	assign event_code = code_q;
	assign last_event = last_q;

	a_pend_cap: assert property (@(posedge clk) disable iff (!arst_n)
		$countones(pend_q) <= jded_pkg::MAX_EVENTS)
		else $error("pending events exceed per-poll cap");

	a_take_empty: assert property (@(posedge clk) disable iff (!arst_n)
		take |-> (pend_q == '0) || (load && $countones(pend_q) == 1))
		else $error("new poll taken over pending events");

	a_held_update: assert property (@(posedge clk) disable iff (!arst_n)
		take |=> held_q == $past(cond))
		else $error("held flags not updated from conditions");

	a_last_drains: assert property (@(posedge clk) disable iff (!arst_n)
		load && (rest == '0) |=> pend_q == '0 || $past(take))
		else $error("pending events left after last beat");

endmodule
